/* sv/stcg_pkg.sv */
`timescale 1ns / 1ps

package stcg_pkg;

  // Token kinds from the lexer
  typedef enum logic [3:0] {
    TOK_END       = 4'd0,
    TOK_LEXERR    = 4'd1,
    TOK_COMMENT   = 4'd2,
    TOK_DATASTART = 4'd3,
    TOK_LOOPSTART = 4'd4,
    TOK_STOP      = 4'd5,
    TOK_TAG       = 4'd6,
    TOK_VALUE     = 4'd7,
    TOK_OTHER     = 4'd8
  } tok_kind_t;

  // Event codes on the result channel
  typedef enum logic [3:0] {
    EV_COMMENT       = 4'd0,
    EV_STARTDATA     = 4'd1,
    EV_ENDDATA       = 4'd2,
    EV_STARTLOOP     = 4'd3,
    EV_ENDLOOP       = 4'd4,
    EV_TAG           = 4'd5,
    EV_VALUE         = 4'd6,
    EV_FATAL         = 4'd7,
    EV_ERR_VAL_EXP   = 4'd8,
    EV_ERR_VAL_UNEXP = 4'd9,
    EV_ERR_NO_TAGS   = 4'd10,
    EV_ERR_NO_VALUES = 4'd11,
    EV_WARN_KEYWORD  = 4'd12,
    EV_WARN_COUNT    = 4'd13,
    EV_INVALID       = 4'd14
  } ev_code_t;

  // Configuration register indexes
  localparam logic REG_STOP_ON_ERROR   = 1'b0;
  localparam logic REG_STOP_ON_WARNING = 1'b1;

  localparam int unsigned MAX_EVENTS = 3;

  // Events caused by one token; line fields travel beside it
  typedef struct packed {
    logic [1:0]          cnt;
    ev_code_t [2:0]      code;
    logic [2:0]          quoting;
    logic [3:0]          bad;
    logic                halt;
  } ev_pkt_t;

  function automatic ev_pkt_t push_ev(ev_pkt_t p, ev_code_t c);
    ev_pkt_t r;
    r = p;
    if (p.cnt != 2'(MAX_EVENTS)) begin
      r.code[p.cnt] = c;
      r.cnt = p.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

/* sv/star_token_grammar_checker.sv */
`timescale 1ns / 1ps
// Grammar checker for a STAR/CIF token stream.
// Input channel (in_*): one lexer token per word, taken when in_valid is high
// and in_stall is low. Output channel (out_*): grammar events, one per word,
// zero to three per token, in order; out_last_event marks a token's final event.
// Configuration (cfg_*): stop_on_error (index 0) and stop_on_warning (index 1),
// written while no token is in flight.
// Throughput: one token per cycle into the front end; events leave at one per
// cycle, so a token that yields several events occupies the output for one
// word per event. The event queue (QUEUE_DEPTH tokens) absorbs such bursts and
// in_stall rises only when it is full.
// With the queue empty, the first event of a token is written into the queue when
// the token is accepted, and from there is loaded into the output register.
// Reset (rst_n low, synchronous) clears the grammar state, the queue and both
// stop registers. After a halting event the block keeps taking tokens and
// drops them until the next reset. When out_stall is high the current event
// holds and the queue fills behind it.
module star_token_grammar_checker #(
  parameter int LINE_BITS      = 24,
  parameter int TAG_COUNT_BITS = 16,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_req_type,
  input  logic [LINE_BITS-1:0] in_token_line,
  input  logic [2:0]           in_value_quoting,
  input  logic                 in_keyword_in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_event_code,
  output logic [LINE_BITS-1:0] out_event_line,
  output logic [2:0]           out_result_quoting,
  output logic [3:0]           out_bad_token,
  output logic                 out_halted,
  output logic                 out_last_event
);

  localparam int PKT_BITS = $bits(stcg_pkg::ev_pkt_t);
  localparam int QW       = PKT_BITS + 2 * LINE_BITS;

  logic                 q_full, q_push, q_pop, q_valid;
  stcg_pkg::ev_pkt_t    f_pkt, b_pkt;
  logic [LINE_BITS-1:0] f_line, f_alt, b_line, b_alt;
  logic [QW-1:0]        q_rdata;

  stcg_front #(
    .LINE_BITS      (LINE_BITS),
    .TAG_COUNT_BITS (TAG_COUNT_BITS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_token_line       (in_token_line),
    .in_value_quoting    (in_value_quoting),
    .in_keyword_in_value (in_keyword_in_value),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_pkt               (f_pkt),
    .q_line              (f_line),
    .q_alt_line          (f_alt)
  );

  stcg_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_pkt, f_line, f_alt}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign b_pkt  = stcg_pkg::ev_pkt_t'(q_rdata[QW-1 -: PKT_BITS]);
  assign b_line = q_rdata[2*LINE_BITS-1 -: LINE_BITS];
  assign b_alt  = q_rdata[LINE_BITS-1:0];

  stcg_back #(
    .LINE_BITS (LINE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_pkt              (b_pkt),
    .q_line             (b_line),
    .q_alt_line         (b_alt),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_code     (out_event_code),
    .out_event_line     (out_event_line),
    .out_result_quoting (out_result_quoting),
    .out_bad_token      (out_bad_token),
    .out_halted         (out_halted),
    .out_last_event     (out_last_event)
  );

endmodule

/* sv/stcg_front.sv */
`timescale 1ns / 1ps

module stcg_front #(
  parameter int LINE_BITS      = 24,
  parameter int TAG_COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            in_req_type,
  input  logic [LINE_BITS-1:0]  in_token_line,
  input  logic [2:0]            in_value_quoting,
  input  logic                  in_keyword_in_value,
  input  logic                  q_full,
  output logic                  q_push,
  output stcg_pkg::ev_pkt_t     q_pkt,
  output logic [LINE_BITS-1:0]  q_line,
  output logic [LINE_BITS-1:0]  q_alt_line
);

  logic stop_err_r, stop_warn_r;

  logic in_blk_r, in_blk_nxt;
  logic fin_r, fin_nxt;
  logic in_loop_r, in_loop_nxt;
  logic rd_hdr_r, rd_hdr_nxt;
  logic vpend_r, vpend_nxt;
  logic any_val_r, any_val_nxt;
  logic prev_vld_r, prev_vld_nxt;
  logic first_vld_r, first_vld_nxt;
  logic [TAG_COUNT_BITS-1:0] hdr_tags_r, hdr_tags_nxt;
  logic [TAG_COUNT_BITS-1:0] row_pos_r, row_pos_nxt;
  logic [TAG_COUNT_BITS-1:0] row_inc;
  logic [LINE_BITS-1:0] prev_line_r, prev_line_nxt;
  logic [LINE_BITS-1:0] first_line_r, first_line_nxt;

  stcg_pkg::ev_pkt_t pkt;
  logic stop;
  logic do_end;
  logic accept;

  assign in_stall   = q_full;
  assign accept     = in_valid && !in_stall;
  assign q_push     = accept && (pkt.cnt != 2'd0);
  assign q_pkt      = pkt;
  assign q_line     = in_token_line;
  // only the loop count warning reports a different line
  assign q_alt_line = first_vld_r ? first_line_r : in_token_line;
  assign row_inc    = row_pos_r + TAG_COUNT_BITS'(1);

  always_comb begin
    in_blk_nxt     = in_blk_r;
    fin_nxt        = fin_r;
    in_loop_nxt    = in_loop_r;
    rd_hdr_nxt     = rd_hdr_r;
    vpend_nxt      = vpend_r;
    any_val_nxt    = any_val_r;
    prev_vld_nxt   = prev_vld_r;
    first_vld_nxt  = first_vld_r;
    hdr_tags_nxt   = hdr_tags_r;
    row_pos_nxt    = row_pos_r;
    prev_line_nxt  = prev_line_r;
    first_line_nxt = first_line_r;
    pkt            = '0;
    pkt.quoting    = in_value_quoting;
    stop           = 1'b0;
    do_end         = 1'b0;

    if (!fin_r) begin
      unique case (in_req_type)
        stcg_pkg::TOK_END: begin
          pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_ENDDATA);
          stop = 1'b1;
        end
        stcg_pkg::TOK_LEXERR: begin
          pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_FATAL);
          stop = 1'b1;
        end
        stcg_pkg::TOK_COMMENT: begin
          pkt = stcg_pkg::push_ev(pkt, stcg_pkg::EV_COMMENT);
        end
        default: begin
          if (!in_blk_r || in_req_type == stcg_pkg::TOK_DATASTART ||
              in_req_type > stcg_pkg::TOK_VALUE) begin
            if (!in_blk_r && in_req_type == stcg_pkg::TOK_DATASTART) begin
              in_blk_nxt = 1'b1;
              pkt = stcg_pkg::push_ev(pkt, stcg_pkg::EV_STARTDATA);
            end else begin
              pkt     = stcg_pkg::push_ev(pkt, stcg_pkg::EV_INVALID);
              pkt.bad = (in_req_type > stcg_pkg::TOK_OTHER) ? stcg_pkg::TOK_OTHER
                                                            : in_req_type;
              stop    = stop_err_r;
            end
          end else if (in_req_type == stcg_pkg::TOK_LOOPSTART) begin
            if (vpend_r) begin
              pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_ERR_VAL_EXP);
              stop = stop_err_r;
            end
            if (!stop) begin
              hdr_tags_nxt   = '0;
              any_val_nxt    = 1'b0;
              row_pos_nxt    = '0;
              prev_line_nxt  = '0;
              prev_vld_nxt   = 1'b0;
              first_line_nxt = '0;
              first_vld_nxt  = 1'b0;
              in_loop_nxt    = 1'b1;
              rd_hdr_nxt     = 1'b1;
              pkt = stcg_pkg::push_ev(pkt, stcg_pkg::EV_STARTLOOP);
            end
          end else if (in_req_type == stcg_pkg::TOK_STOP) begin
            do_end = 1'b1;
          end else if (in_req_type == stcg_pkg::TOK_TAG) begin
            if (in_loop_r) begin
              if (rd_hdr_r) begin
                if (hdr_tags_r != '1) hdr_tags_nxt = hdr_tags_r + TAG_COUNT_BITS'(1);
                pkt = stcg_pkg::push_ev(pkt, stcg_pkg::EV_TAG);
              end else begin
                do_end = 1'b1;
              end
            end else begin
              if (vpend_r) begin
                pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_ERR_VAL_EXP);
                stop = stop_err_r;
              end
              if (!stop) begin
                vpend_nxt = 1'b1;
                pkt = stcg_pkg::push_ev(pkt, stcg_pkg::EV_TAG);
              end
            end
          end else begin
            // value token
            if (in_loop_r) begin
              if (hdr_tags_r == '0) begin
                pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_ERR_NO_TAGS);
                stop = stop_err_r;
              end
              if (!stop) begin
                rd_hdr_nxt  = 1'b0;
                any_val_nxt = 1'b1;
                if (hdr_tags_r != '0) begin
                  if (row_inc == hdr_tags_r) begin
                    // row complete: track first and latest row lines
                    if (!prev_vld_r || prev_line_r < in_token_line) begin
                      if (!first_vld_r) begin
                        first_line_nxt = in_token_line;
                        first_vld_nxt  = 1'b1;
                      end
                      prev_line_nxt = in_token_line;
                      prev_vld_nxt  = 1'b1;
                    end
                    row_pos_nxt = '0;
                  end else begin
                    row_pos_nxt = row_inc;
                  end
                end
              end
            end else begin
              if (!vpend_r) begin
                pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_ERR_VAL_UNEXP);
                stop = stop_err_r;
              end
              if (!stop) vpend_nxt = 1'b0;
            end
            if (!stop && in_keyword_in_value) begin
              pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_WARN_KEYWORD);
              stop = stop_warn_r;
            end
            if (!stop) pkt = stcg_pkg::push_ev(pkt, stcg_pkg::EV_VALUE);
          end

          // loop close, from stop or from a tag after the rows
          if (do_end) begin
            in_loop_nxt = 1'b0;
            if (!any_val_r) begin
              pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_ERR_NO_VALUES);
              stop = stop_err_r;
            end
            if (!stop && hdr_tags_r != '0 && row_pos_r != '0) begin
              pkt  = stcg_pkg::push_ev(pkt, stcg_pkg::EV_WARN_COUNT);
              stop = stop_warn_r;
            end
            if (!stop) pkt = stcg_pkg::push_ev(pkt, stcg_pkg::EV_ENDLOOP);
            if (!stop && in_req_type == stcg_pkg::TOK_TAG) begin
              pkt       = stcg_pkg::push_ev(pkt, stcg_pkg::EV_TAG);
              vpend_nxt = 1'b1;
            end
          end
        end
      endcase
      if (stop) begin
        fin_nxt  = 1'b1;
        pkt.halt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_err_r  <= 1'b0;
      stop_warn_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        stcg_pkg::REG_STOP_ON_ERROR:   stop_err_r  <= cfg_wdata;
        stcg_pkg::REG_STOP_ON_WARNING: stop_warn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_blk_r     <= 1'b0;
      fin_r        <= 1'b0;
      in_loop_r    <= 1'b0;
      rd_hdr_r     <= 1'b1;
      vpend_r      <= 1'b0;
      any_val_r    <= 1'b0;
      prev_vld_r   <= 1'b0;
      first_vld_r  <= 1'b0;
      hdr_tags_r   <= '0;
      row_pos_r    <= '0;
      prev_line_r  <= '0;
      first_line_r <= '0;
    end else if (accept) begin
      in_blk_r     <= in_blk_nxt;
      fin_r        <= fin_nxt;
      in_loop_r    <= in_loop_nxt;
      rd_hdr_r     <= rd_hdr_nxt;
      vpend_r      <= vpend_nxt;
      any_val_r    <= any_val_nxt;
      prev_vld_r   <= prev_vld_nxt;
      first_vld_r  <= first_vld_nxt;
      hdr_tags_r   <= hdr_tags_nxt;
      row_pos_r    <= row_pos_nxt;
      prev_line_r  <= prev_line_nxt;
      first_line_r <= first_line_nxt;
    end
  end

endmodule

/* sv/stcg_queue.sv */
`timescale 1ns / 1ps

module stcg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

/* sv/stcg_back.sv */
`timescale 1ns / 1ps

module stcg_back #(
  parameter int LINE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  stcg_pkg::ev_pkt_t    q_pkt,
  input  logic [LINE_BITS-1:0] q_line,
  input  logic [LINE_BITS-1:0] q_alt_line,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_event_code,
  output logic [LINE_BITS-1:0] out_event_line,
  output logic [2:0]           out_result_quoting,
  output logic [3:0]           out_bad_token,
  output logic                 out_halted,
  output logic                 out_last_event
);

  logic [1:0]          idx_r;
  logic                vld_r;
  stcg_pkg::ev_code_t  code_r;
  logic [LINE_BITS-1:0] line_r;
  logic [2:0]          quot_r;
  logic [3:0]          bad_r;
  logic                halted_r, last_r;

  stcg_pkg::ev_code_t  cur;
  logic                load, last;

  assign load  = q_valid && (!vld_r || !out_stall);
  assign cur   = q_pkt.code[idx_r];
  assign last  = (idx_r + 2'd1 == q_pkt.cnt);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r   <= cur;
      line_r   <= (cur == stcg_pkg::EV_WARN_COUNT) ? q_alt_line : q_line;
      quot_r   <= (cur == stcg_pkg::EV_VALUE) ? q_pkt.quoting : 3'd0;
      bad_r    <= (cur == stcg_pkg::EV_INVALID) ? q_pkt.bad : 4'd0;
      halted_r <= last && q_pkt.halt;
      last_r   <= last;
    end
  end

  assign out_valid          = vld_r;
  assign out_event_code     = code_r;
  assign out_event_line     = line_r;
  assign out_result_quoting = quot_r;
  assign out_bad_token      = bad_r;
  assign out_halted         = halted_r;
  assign out_last_event     = last_r;

endmodule

/* sv/stcg_checker.sv */
`timescale 1ns / 1ps

module stcg_checker #(
  parameter int LINE_BITS = 24
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [3:0]           out_event_code,
  input logic [LINE_BITS-1:0] out_event_line,
  input logic [2:0]           out_result_quoting,
  input logic [3:0]           out_bad_token,
  input logic                 out_halted,
  input logic                 out_last_event
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code) &&
      $stable(out_event_line) && $stable(out_halted) && $stable(out_last_event))
    else $error("stalled event changed");

  // nothing follows the halting event
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_halted |=> !out_valid)
    else $error("event after halt");

  a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> out_last_event)
    else $error("halt not on last event of token");

  // end and lexer error always stop the block on their own
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code == stcg_pkg::EV_ENDDATA ||
                  out_event_code == stcg_pkg::EV_FATAL)
      |-> out_halted && out_last_event)
    else $error("end or fatal did not halt");

  a_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code != stcg_pkg::EV_INVALID &&
      out_event_code != stcg_pkg::EV_VALUE
      |-> out_bad_token == 4'd0 && out_result_quoting == 3'd0)
    else $error("side field set on plain event");

endmodule

bind star_token_grammar_checker stcg_checker #(.LINE_BITS(LINE_BITS)) u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_event_code     (out_event_code),
  .out_event_line     (out_event_line),
  .out_result_quoting (out_result_quoting),
  .out_bad_token      (out_bad_token),
  .out_halted         (out_halted),
  .out_last_event     (out_last_event)
);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int LINE_W = 24;
  // narrow tag counter so header saturation and row wrap are reachable
  localparam int TAG_W = 4;
  localparam logic [3:0] KIND_MAX = 4'hF;

  typedef struct packed {
    logic [3:0]        kind;
    logic [LINE_W-1:0] line;
    logic [2:0]        quoting;
    logic              kw;
  } token_t;

  typedef struct packed {
    stcg_pkg::ev_code_t code;
    logic [LINE_W-1:0]  line;
    logic [2:0]         quoting;
    logic [3:0]         bad;
    logic               halted;
    logic               last;
  } grammar_event_t;

  typedef struct {
    logic              in_block;
    logic              finished;
    logic              in_loop;
    logic              reading_hdr;
    logic              val_pending;
    logic [TAG_W-1:0]  hdr_tags;
    logic              any_val;
    logic [TAG_W-1:0]  row_pos;
    logic [LINE_W-1:0] prev_line;
    logic              prev_ok;
    logic [LINE_W-1:0] first_line;
    logic              first_ok;
  } parse_state_t;

  class grammar_tracker;
    logic stop_err;
    logic stop_warn;
    parse_state_t st;
    parse_state_t w;
    grammar_event_t produced[$];
    grammar_event_t expected_events[$];
    int n_fail;

    function new();
      stop_err = 1'b0;
      stop_warn = 1'b0;
      st = '{default: 0};
      st.reading_hdr = 1'b1;
      n_fail = 0;
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == stcg_pkg::REG_STOP_ON_ERROR) stop_err = val;
      else stop_warn = val;
    endfunction

    function void emit(stcg_pkg::ev_code_t code, logic [LINE_W-1:0] line,
                       logic [2:0] quoting = 3'd0, logic [3:0] bad = 4'd0);
      grammar_event_t e;
      if (produced.size() >= stcg_pkg::MAX_EVENTS) return;
      e = '0;
      e.code = code;
      e.line = line;
      e.quoting = quoting;
      e.bad = bad;
      produced.push_back(e);
    endfunction

    function void halt_now();
      grammar_event_t e;
      w.finished = 1'b1;
      if (produced.size() > 0) begin
        e = produced.pop_back();
        e.halted = 1'b1;
        produced.push_back(e);
      end
    endfunction

    function bit raise_error(stcg_pkg::ev_code_t code, logic [LINE_W-1:0] line,
                             logic [3:0] bad);
      emit(code, line, 3'd0, bad);
      if (stop_err) begin
        halt_now();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit raise_warning(stcg_pkg::ev_code_t code, logic [LINE_W-1:0] line);
      emit(code, line);
      if (stop_warn) begin
        halt_now();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit close_loop(logic [LINE_W-1:0] line);
      if (!w.any_val) begin
        if (raise_error(stcg_pkg::EV_ERR_NO_VALUES, line, 4'd0)) return 1'b1;
      end
      if (w.hdr_tags != 0 && w.row_pos != 0) begin
        if (raise_warning(stcg_pkg::EV_WARN_COUNT, w.first_ok ? w.first_line : line))
          return 1'b1;
      end
      emit(stcg_pkg::EV_ENDLOOP, line);
      return 1'b0;
    endfunction

    function void open_loop(logic [LINE_W-1:0] line);
      // a free tag still waiting is reported but stays pending
      if (w.val_pending) begin
        if (raise_error(stcg_pkg::EV_ERR_VAL_EXP, line, 4'd0)) return;
      end
      w.hdr_tags = '0;
      w.any_val = 1'b0;
      w.row_pos = '0;
      w.prev_line = '0;
      w.prev_ok = 1'b0;
      w.first_line = '0;
      w.first_ok = 1'b0;
      w.in_loop = 1'b1;
      w.reading_hdr = 1'b1;
      emit(stcg_pkg::EV_STARTLOOP, line);
    endfunction

    function void take_tag(logic [LINE_W-1:0] line);
      if (w.in_loop) begin
        if (w.reading_hdr) begin
          if (w.hdr_tags != {TAG_W{1'b1}}) w.hdr_tags = w.hdr_tags + 1'b1;
          emit(stcg_pkg::EV_TAG, line);
        end else begin
          // a tag after the rows closes the loop and starts a free pair
          w.in_loop = 1'b0;
          if (close_loop(line)) return;
          emit(stcg_pkg::EV_TAG, line);
          w.val_pending = 1'b1;
        end
      end else begin
        if (w.val_pending) begin
          if (raise_error(stcg_pkg::EV_ERR_VAL_EXP, line, 4'd0)) return;
        end
        w.val_pending = 1'b1;
        emit(stcg_pkg::EV_TAG, line);
      end
    endfunction

    function void take_value(token_t t);
      if (w.in_loop) begin
        if (w.hdr_tags == 0) begin
          if (raise_error(stcg_pkg::EV_ERR_NO_TAGS, t.line, 4'd0)) return;
        end
        w.reading_hdr = 1'b0;
        w.any_val = 1'b1;
        if (w.hdr_tags != 0) begin
          w.row_pos = w.row_pos + 1'b1;
          if (w.row_pos == w.hdr_tags) begin
            if (!w.prev_ok || w.prev_line < t.line) begin
              if (!w.first_ok) begin
                w.first_line = t.line;
                w.first_ok = 1'b1;
              end
              w.prev_line = t.line;
              w.prev_ok = 1'b1;
            end
            w.row_pos = '0;
          end
        end
      end else begin
        if (!w.val_pending) begin
          if (raise_error(stcg_pkg::EV_ERR_VAL_UNEXP, t.line, 4'd0)) return;
        end
        w.val_pending = 1'b0;
      end
      if (t.kw) begin
        if (raise_warning(stcg_pkg::EV_WARN_KEYWORD, t.line)) return;
      end
      emit(stcg_pkg::EV_VALUE, t.line, t.quoting);
    endfunction

    // works on w and fills produced
    function void parse_token(token_t t);
      logic [3:0] bad_kind;
      grammar_event_t e;
      bad_kind = (t.kind > stcg_pkg::TOK_OTHER) ? 4'(stcg_pkg::TOK_OTHER) : t.kind;
      produced.delete();
      if (w.finished) return;
      if (t.kind == stcg_pkg::TOK_END) begin
        emit(stcg_pkg::EV_ENDDATA, t.line);
        halt_now();
      end else if (t.kind == stcg_pkg::TOK_LEXERR) begin
        emit(stcg_pkg::EV_FATAL, t.line);
        halt_now();
      end else if (t.kind == stcg_pkg::TOK_COMMENT) begin
        emit(stcg_pkg::EV_COMMENT, t.line);
      end else if (!w.in_block) begin
        if (t.kind == stcg_pkg::TOK_DATASTART) begin
          w.in_block = 1'b1;
          emit(stcg_pkg::EV_STARTDATA, t.line);
        end else begin
          void'(raise_error(stcg_pkg::EV_INVALID, t.line, bad_kind));
        end
      end else begin
        case (t.kind)
          stcg_pkg::TOK_LOOPSTART: open_loop(t.line);
          stcg_pkg::TOK_STOP: begin
            w.in_loop = 1'b0;
            void'(close_loop(t.line));
          end
          stcg_pkg::TOK_TAG: take_tag(t.line);
          stcg_pkg::TOK_VALUE: take_value(t);
          default: void'(raise_error(stcg_pkg::EV_INVALID, t.line, bad_kind));
        endcase
      end
      if (produced.size() > 0) begin
        e = produced.pop_back();
        e.last = 1'b1;
        produced.push_back(e);
      end
    endfunction

    function bit would_halt(token_t t);
      w = st;
      parse_token(t);
      return w.finished;
    endfunction

    function void note_token(token_t t);
      w = st;
      parse_token(t);
      st = w;
      foreach (produced[i]) expected_events.push_back(produced[i]);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        n_fail++;
      end
    endfunction

    function void check_event(logic [3:0] code, logic [LINE_W-1:0] line, logic [2:0] quoting,
                              logic [3:0] bad, logic halted, logic last);
      grammar_event_t want;
      if (expected_events.size() == 0) begin
        $error("unexpected event: code %0d line %0d", code, line);
        n_fail++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_code", want.code, code);
      compare_field("event_line", want.line, line);
      compare_field("result_quoting", want.quoting, quoting);
      compare_field("bad_token", want.bad, bad);
      compare_field("halted", want.halted, halted);
      compare_field("last_event", want.last, last);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_index;
  logic              cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [3:0]        in_req_type;
  logic [LINE_W-1:0] in_token_line;
  logic [2:0]        in_value_quoting;
  logic              in_keyword_in_value;
  logic              out_valid;
  logic              out_stall;
  logic [3:0]        out_event_code;
  logic [LINE_W-1:0] out_event_line;
  logic [2:0]        out_result_quoting;
  logic [3:0]        out_bad_token;
  logic              out_halted;
  logic              out_last_event;

  grammar_tracker    tracker;
  token_t            plan[$];
  logic [LINE_W-1:0] next_line;
  int                sent;
  int                gap_odds;
  bit                calm;
  bit                hold_req;

  star_token_grammar_checker #(
    .LINE_BITS      (LINE_W),
    .TAG_COUNT_BITS (TAG_W)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_token_line       (in_token_line),
    .in_value_quoting    (in_value_quoting),
    .in_keyword_in_value (in_keyword_in_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_code      (out_event_code),
    .out_event_line      (out_event_line),
    .out_result_quoting  (out_result_quoting),
    .out_bad_token       (out_bad_token),
    .out_halted          (out_halted),
    .out_last_event      (out_last_event)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_event(out_event_code, out_event_line, out_result_quoting,
                          out_bad_token, out_halted, out_last_event);
    end
  end

  // receiver: random stall bursts, quiet stretches, and one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  function automatic token_t tok(logic [3:0] kind);
    token_t t;
    case ($urandom_range(0, 15))
      0: next_line = LINE_W'($urandom());
      1: next_line = next_line - LINE_W'($urandom_range(1, 3));
      default: next_line = next_line + LINE_W'($urandom_range(0, 2));
    endcase
    t.kind = kind;
    t.line = next_line;
    t.quoting = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) :
                                              3'($urandom_range(0, 4));
    t.kw = ($urandom_range(0, 9) == 0);
    return t;
  endfunction

  // mostly well-formed loops and tag/value pairs; some noise and broken sequences
  function automatic void plan_sequence();
    int shape;
    int n_tags;
    int n_vals;
    int pos;
    plan.delete();
    shape = $urandom_range(0, 9);
    if (shape <= 5) begin
      plan.push_back(tok(stcg_pkg::TOK_LOOPSTART));
      case ($urandom_range(0, 19))
        0, 1: n_tags = 0;
        2: n_tags = $urandom_range(14, 18);
        default: n_tags = $urandom_range(1, 5);
      endcase
      repeat (n_tags) plan.push_back(tok(stcg_pkg::TOK_TAG));
      if (n_tags == 0) n_vals = $urandom_range(0, 2);
      else if (n_tags > 5) n_vals = n_tags;
      else n_vals = n_tags * $urandom_range(1, 3);
      repeat (n_vals) begin
        if ($urandom_range(0, 11) == 0) plan.push_back(tok(stcg_pkg::TOK_COMMENT));
        plan.push_back(tok(stcg_pkg::TOK_VALUE));
      end
      case ($urandom_range(0, 2))
        0: plan.push_back(tok(stcg_pkg::TOK_STOP));
        1: begin
          plan.push_back(tok(stcg_pkg::TOK_TAG));
          plan.push_back(tok(stcg_pkg::TOK_VALUE));
        end
        default: ;
      endcase
    end else if (shape <= 7) begin
      repeat ($urandom_range(1, 3)) begin
        plan.push_back(tok(stcg_pkg::TOK_TAG));
        plan.push_back(tok(stcg_pkg::TOK_VALUE));
      end
    end else if (shape == 8) begin
      plan.push_back(tok(stcg_pkg::TOK_COMMENT));
    end else begin
      repeat ($urandom_range(1, 4)) plan.push_back(tok(4'($urandom_range(0, KIND_MAX))));
    end
    if (plan.size() > 1 && $urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, plan.size() - 1);
      if ($urandom_range(0, 1) == 1) plan.delete(pos);
      else plan.insert(pos, plan[pos]);
    end
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_word(input token_t t);
    in_valid <= 1'b1;
    in_req_type <= t.kind;
    in_token_line <= t.line;
    in_value_quoting <= t.quoting;
    in_keyword_in_value <= t.kw;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_token(t);
    sent++;
    @(negedge clk);
  endtask

  task automatic pause_in(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_token(input logic [3:0] kind, input int unsigned line,
                            input logic [2:0] quoting = 3'd0, input logic kw = 1'b0);
    token_t t;
    t.kind = kind;
    t.line = LINE_W'(line);
    t.quoting = quoting;
    t.kw = kw;
    drive_word(t);
  endtask

  task automatic send_plan(input bit allow_halt);
    token_t t;
    gap_odds = $urandom_range(0, 4);
    foreach (plan[i]) begin
      t = plan[i];
      // the block can only halt once per run, so defer halting words to the end
      if (!allow_halt && tracker.would_halt(t)) t.kind = stcg_pkg::TOK_COMMENT;
      drive_word(t);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        pause_in($urandom_range(1, 18));
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  task automatic wait_results();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (tracker.expected_events.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    if (tracker.expected_events.size() != 0) begin
      $error("%0d expected events never arrived", tracker.expected_events.size());
      tracker.n_fail++;
      tracker.expected_events.delete();
    end
    // halted words produce nothing, so give the queue time to flush
    repeat (12) @(negedge clk);
  endtask

  task automatic run_phase(input logic err, input logic warn, input int n_items);
    int start;
    write_reg(stcg_pkg::REG_STOP_ON_ERROR, err);
    write_reg(stcg_pkg::REG_STOP_ON_WARNING, warn);
    start = sent;
    while (sent - start < n_items) begin
      plan_sequence();
      send_plan(1'b0);
    end
    wait_results();
  endtask

  initial begin
    int mode;
    int start;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_token_line = '0;
    in_value_quoting = '0;
    in_keyword_in_value = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    gap_odds = 0;
    tracker = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_reg(stcg_pkg::REG_STOP_ON_ERROR, 1'b0);
    write_reg(stcg_pkg::REG_STOP_ON_WARNING, 1'b0);

    // file level: comment, words that are invalid outside a block, data start, invalid second data start
    send_token(stcg_pkg::TOK_COMMENT, 0);
    send_token(stcg_pkg::TOK_LOOPSTART, 1);
    send_token(stcg_pkg::TOK_VALUE, 2, 3'd3, 1'b1);
    send_token(KIND_MAX, 3);
    send_token(stcg_pkg::TOK_DATASTART, 4);
    send_token(stcg_pkg::TOK_DATASTART, 5);
    // free pairs: keyword warning, unexpected value
    send_token(stcg_pkg::TOK_TAG, 6);
    send_token(stcg_pkg::TOK_VALUE, 24'hFFFFFF, 3'd7, 1'b1);
    send_token(stcg_pkg::TOK_VALUE, 7, 3'd1);
    // pending tag survives a loop with no header tags
    send_token(stcg_pkg::TOK_TAG, 8);
    send_token(stcg_pkg::TOK_LOOPSTART, 9);
    send_token(stcg_pkg::TOK_VALUE, 10, 3'd2);
    send_token(stcg_pkg::TOK_STOP, 11);
    send_token(stcg_pkg::TOK_TAG, 12);
    send_token(stcg_pkg::TOK_VALUE, 13, 3'd4);
    // short last row, closed by a tag: count warning, endloop and tag in one word
    send_token(stcg_pkg::TOK_LOOPSTART, 14);
    send_token(stcg_pkg::TOK_TAG, 15);
    send_token(stcg_pkg::TOK_TAG, 16);
    send_token(stcg_pkg::TOK_VALUE, 100);
    send_token(stcg_pkg::TOK_VALUE, 100);
    send_token(stcg_pkg::TOK_VALUE, 101);
    send_token(stcg_pkg::TOK_TAG, 102);
    // stop with no open loop reuses the old counters
    send_token(stcg_pkg::TOK_STOP, 103);
    send_token(stcg_pkg::TOK_LOOPSTART, 104);
    send_token(stcg_pkg::TOK_TAG, 105);
    send_token(stcg_pkg::TOK_STOP, 106);
    send_token(stcg_pkg::TOK_OTHER, 107);
    wait_results();

    next_line = 200;
    hold_req = 1'b1;
    run_phase(1'b1, 1'b0, 75);
    run_phase(1'b0, 1'b1, 75);
    run_phase(1'b1, 1'b1, 75);
    run_phase(1'b0, 1'b0, 75);

    // last part: no idling, halt the block, then words it must drop
    calm = 1'b1;
    write_reg(stcg_pkg::REG_STOP_ON_ERROR, 1'($urandom_range(0, 1)));
    write_reg(stcg_pkg::REG_STOP_ON_WARNING, 1'($urandom_range(0, 1)));
    mode = $urandom_range(0, 2);
    if (mode == 2) begin
      start = sent;
      while (!tracker.st.finished && sent - start < 30) begin
        plan_sequence();
        send_plan(1'b1);
      end
    end
    plan.delete();
    plan.push_back(tok(stcg_pkg::TOK_LOOPSTART));
    plan.push_back(tok(stcg_pkg::TOK_TAG));
    plan.push_back(tok(stcg_pkg::TOK_VALUE));
    plan.push_back(tok(mode == 1 ? stcg_pkg::TOK_LEXERR : stcg_pkg::TOK_END));
    repeat (4) plan.push_back(tok(4'($urandom_range(0, KIND_MAX))));
    send_plan(1'b1);
    wait_results();
    repeat (20) @(negedge clk);
    if (tracker.n_fail == 0) begin
      $display("PASS star_token_grammar_checker");
    end else begin
      $display("FAIL star_token_grammar_checker");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL star_token_grammar_checker");
    $finish;
  end

endmodule

/* filelist.f */
sv/stcg_pkg.sv
sv/stcg_front.sv
sv/stcg_queue.sv
sv/stcg_back.sv
sv/star_token_grammar_checker.sv
sv/stcg_checker.sv
verif/tb.sv
